FILE: design/arprr_pkg.sv
package arprr_pkg;

    // Field widths fixed by the ARP frame format and the stream layout.
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int S_DATA_W  = 240;
    localparam int M_DATA_W  = 184;
    localparam int M_USER_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 2'd1;

    // Protocol constants.
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] HW_TYPE_ETH   = 16'h0001;
    localparam logic [15:0] OPER_REQUEST  = 16'h0001;
    localparam logic [15:0] OPER_REPLY    = 16'h0002;
    localparam logic [7:0]  ARP_HLN       = 8'd6;
    localparam logic [7:0]  ARP_PLN       = 8'd4;
    localparam logic [10:0] ARP_MIN_LEN   = 11'd28;
    localparam logic [IP_W-1:0]  IP_BROADCAST  = '1;
    localparam logic [MAC_W-1:0] MAC_BROADCAST = '1;

    // Opcode of the frame to send.
    localparam logic [1:0] OPC_NONE = 2'd0;
    localparam logic [1:0] OPC_REQ  = 2'd1;
    localparam logic [1:0] OPC_REP  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOOKUP,
        CMD_IGNORE,
        CMD_REPLY,
        CMD_LEARN
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op          op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_cmd;

    typedef enum logic [2:0] {
        K_HIT      = 3'd0,
        K_SENDREQ  = 3'd1,
        K_RESOLVED = 3'd2,
        K_SENDREP  = 3'd3,
        K_IGNORED  = 3'd4,
        K_OVERFLOW = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [1:0]       opcode;
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] tgt_mac;
        logic [IP_W-1:0]  tgt_ip;
        logic [MAC_W-1:0] res_mac;
    } t_res;

endpackage

FILE: design/arprr_front.sv
module arprr_front
    import arprr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_req_type,
    input  logic [S_DATA_W-1:0]  i_data,
    output t_cmd                 o_cmd
);

    logic [IP_W-1:0] r_own_ip;

    logic [IP_W-1:0]  w_lookup_ip;
    logic [15:0]      w_ethertype;
    logic [10:0]      w_length;
    logic [15:0]      w_hw_type;
    logic [15:0]      w_proto_type;
    logic [7:0]       w_hln;
    logic [7:0]       w_pln;
    logic [15:0]      w_opcode;
    logic [MAC_W-1:0] w_sender_mac;
    logic [IP_W-1:0]  w_sender_ip;
    logic [IP_W-1:0]  w_target_ip;
    logic             w_frame_ok;
    logic             w_for_us;

    // The own MAC address is only the sender field of outgoing frames, which
    // are built downstream; its writes are accepted and not kept here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_valid && i_cfg_index == REG_OWN_IP) begin
            r_own_ip <= i_cfg_data[IP_W-1:0];
        end
    end

    assign w_lookup_ip  = i_data[31:0];
    assign w_ethertype  = i_data[47:32];
    assign w_length     = i_data[58:48];
    assign w_hw_type    = i_data[74:59];
    assign w_proto_type = i_data[90:75];
    assign w_hln        = i_data[98:91];
    assign w_pln        = i_data[106:99];
    assign w_opcode     = i_data[122:107];
    assign w_sender_mac = i_data[170:123];
    assign w_sender_ip  = i_data[202:171];
    assign w_target_ip  = i_data[234:203];

    assign w_frame_ok = (w_length >= ARP_MIN_LEN) && (w_ethertype == ETH_TYPE_ARP)
                     && (w_hw_type == HW_TYPE_ETH) && (w_proto_type == ETH_TYPE_IPV4)
                     && (w_hln == ARP_HLN) && (w_pln == ARP_PLN);
    assign w_for_us = (w_target_ip == r_own_ip);

    always_comb begin
        o_cmd.ip  = w_sender_ip;
        o_cmd.mac = w_sender_mac;
        priority if (!i_req_type) begin
            o_cmd.op  = CMD_LOOKUP;
            o_cmd.ip  = w_lookup_ip;
        end else if (!w_frame_ok || !w_for_us) begin
            o_cmd.op = CMD_IGNORE;
        end else if (w_opcode == OPER_REQUEST) begin
            o_cmd.op = CMD_REPLY;
        end else if (w_opcode == OPER_REPLY) begin
            o_cmd.op = CMD_LEARN;
        end else begin
            o_cmd.op = CMD_IGNORE;
        end
    end

endmodule

FILE: design/arprr_fifo.sv
module arprr_fifo
    import arprr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("command queue count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("command queue pointers disagree with count");
`endif

endmodule

FILE: design/arprr_back.sv
module arprr_back
    import arprr_pkg::*;
#(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam int AW    = $clog2(CACHE_ENTRIES);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC,
        S_EMIT
    } t_state;

    // Entry 0 is the fixed broadcast mapping and is never stored here.
    logic [IP_W-1:0]  mem_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0] mem_mac [CACHE_ENTRIES];

    t_state           r_state;
    t_cmd             r_cmd;
    t_res             r_res;
    t_res             r_out;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_cmp_vld;
    logic             r_pending;
    logic [IP_W-1:0]  r_pend_ip;
    logic [IP_W-1:0]  r_rd_ip;
    logic [MAC_W-1:0] r_rd_mac;

    logic w_learn;
    logic w_out_free;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_learn    = (r_state == S_EXEC) && (r_cmd.op == CMD_LEARN) && r_pending
                     && (r_count < FULL_CNT) && (r_pend_ip == r_cmd.ip);

    always_ff @(posedge i_clk) begin
        if (w_learn) begin
            mem_ip[r_count[AW-1:0]]  <= r_pend_ip;
            mem_mac[r_count[AW-1:0]] <= r_cmd.mac;
        end
        r_rd_ip  <= mem_ip[r_idx[AW-1:0]];
        r_rd_mac <= mem_mac[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= CNT_W'(1);
            r_idx       <= CNT_W'(1);
            r_cmp_vld   <= 1'b0;
            r_pending   <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd     <= i_cmd;
                        r_idx     <= CNT_W'(1);
                        r_cmp_vld <= 1'b0;
                        r_state   <= (i_cmd.op == CMD_LOOKUP) ? S_SEARCH : S_EXEC;
                    end
                end
                S_SEARCH: begin
                    // One cache read is issued per cycle; its data is compared
                    // in the next cycle while the next read goes out.
                    priority if (r_cmd.ip == IP_BROADCAST) begin
                        r_res   <= '{kind: K_HIT, opcode: OPC_NONE,
                                     res_mac: MAC_BROADCAST, default: '0};
                        r_state <= S_EMIT;
                    end else if (r_cmp_vld && r_rd_ip == r_cmd.ip) begin
                        r_res   <= '{kind: K_HIT, opcode: OPC_NONE,
                                     res_mac: r_rd_mac, default: '0};
                        r_state <= S_EMIT;
                    end else if (r_idx == r_count) begin
                        if (r_count >= FULL_CNT) begin
                            r_res <= '{kind: K_OVERFLOW, opcode: OPC_NONE, default: '0};
                        end else begin
                            r_pending <= 1'b1;
                            r_pend_ip <= r_cmd.ip;
                            r_res     <= '{kind: K_SENDREQ, opcode: OPC_REQ,
                                           dest_mac: MAC_BROADCAST, tgt_ip: r_cmd.ip,
                                           default: '0};
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_idx     <= r_idx + CNT_W'(1);
                        r_cmp_vld <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (r_cmd.op == CMD_REPLY) begin
                        r_res <= '{kind: K_SENDREP, opcode: OPC_REP,
                                   dest_mac: r_cmd.mac, tgt_mac: r_cmd.mac,
                                   tgt_ip: r_cmd.ip, default: '0};
                    end else if (w_learn) begin
                        r_count   <= r_count + CNT_W'(1);
                        r_pending <= 1'b0;
                        r_res     <= '{kind: K_RESOLVED, opcode: OPC_NONE,
                                       res_mac: r_cmd.mac, default: '0};
                    end else begin
                        r_res <= '{kind: K_IGNORED, opcode: OPC_NONE, default: '0};
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(1)) && (r_count <= FULL_CNT))
        else $error("cache entry count out of range");
    a_pending_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_count < FULL_CNT))
        else $error("resolve pending with a full cache");
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_ready) |=> (r_state == S_EMIT))
        else $error("result left the emit state while the output was blocked");
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_idx <= r_count))
        else $error("cache search ran past the entries in use");
`endif

endmodule

FILE: design/arp_resolver_responder.sv
// ARP cache and responder for IPv4 over Ethernet. Each input word is a
// resolve request (tuser 0) or a received ARP frame (tuser 1) and yields
// exactly one result word, in order. The front end validates and classifies
// a word in the cycle it is accepted and queues a command in a two-deep
// queue; the back end executes commands one at a time against the cache.
// A resolve request reads one cache entry per cycle through the one read
// port of the cache memory until it hits or runs out of entries. Entry 0
// always maps the broadcast address and needs no initialization, so the
// block is ready straight out of reset. The result register lets the
// next word be accepted while a result waits to be taken.
module arp_resolver_responder
    import arprr_pkg::*;
#(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,  // 0 own_mac, 1 own_ip
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // lookup_ip, frame_ethertype, frame_length, hw_type, proto_type,
    // hw_addr_len, proto_addr_len, arp_opcode, sender_mac, sender_ip,
    // target_ip_in, zero padding
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    input  logic                 s_axis_tuser,  // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_opcode, dest_mac, out_target_mac, out_target_ip, resolved_mac,
    // zero padding
    output logic [M_DATA_W-1:0]  m_axis_tdata,
    output logic [M_USER_W-1:0]  m_axis_tuser   // result_kind
);

    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;
    t_res w_res;
    logic w_full;
    logic w_empty;
    logic w_pop;
    logic w_push;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    arprr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .o_cmd       (w_front_cmd)
    );

    arprr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_queue_cmd)
    );

    arprr_back #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_queue_cmd),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tdata = {6'd0, w_res.res_mac, w_res.tgt_ip, w_res.tgt_mac,
                           w_res.dest_mac, w_res.opcode};

endmodule
